### sv/fwalu_pkg.sv
// Shared types and constants for the fixed-width unsigned ALU.
package fwalu_pkg;

   localparam int WIDTH = 64;
   localparam int COUNT_WIDTH = $clog2(WIDTH);

   localparam int OP_WIDTH = 4;
   localparam int FIELD_WIDTH = 64;
   localparam int SHIFT_WIDTH = 7;

   // request tdata layout, lowest bit up: op, operand_a, operand_b, shift_amount
   localparam int REQ_OP_LSB = 0;
   localparam int REQ_A_LSB = REQ_OP_LSB + OP_WIDTH;
   localparam int REQ_B_LSB = REQ_A_LSB + FIELD_WIDTH;
   localparam int REQ_SH_LSB = REQ_B_LSB + FIELD_WIDTH;
   localparam int REQ_BITS = REQ_SH_LSB + SHIFT_WIDTH;
   localparam int REQ_TDATA_WIDTH = ((REQ_BITS + 7) / 8) * 8;

   // response tdata layout, lowest bit up: result_value, compare_true, divide_by_zero
   localparam int RSP_BITS = FIELD_WIDTH + 2;
   localparam int RSP_TDATA_WIDTH = ((RSP_BITS + 7) / 8) * 8;

   typedef enum logic [OP_WIDTH-1:0] {
      OP_ADD = 4'd0,
      OP_SUB = 4'd1,
      OP_MUL = 4'd2,
      OP_DIV = 4'd3,
      OP_MOD = 4'd4,
      OP_SHL = 4'd5,
      OP_SHR = 4'd6,
      OP_GT  = 4'd7,
      OP_LT  = 4'd8,
      OP_EQ  = 4'd9,
      OP_LE  = 4'd10,
      OP_GE  = 4'd11
   } op_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_DECIDE,
      S_RUN,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic write_out;
   } ctrl_cmd_type;

   typedef struct packed {
      logic iterative;
      logic last;
   } dp_status_type;

endpackage

### sv/fixed_width_unsigned_alu.sv
// Top level of the fixed-width unsigned ALU: controller plus datapath.
// Add, sub, shifts, compares and a zero divisor pass from the decide state straight to finish.
// Multiply, and divide or modulo with a nonzero divisor, go through the run state in between,
// driven by the one-bit-per-cycle shift-add and restoring subtract loop in the datapath.
// One request in flight; a new one is taken while the last response waits.
// Synchronous active-high reset clears the state machine and response valid only.
module fixed_width_unsigned_alu (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // op, operand_a, operand_b, shift_amount, zero fill
   input  logic [fwalu_pkg::REQ_TDATA_WIDTH-1:0] req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // result_value, compare_true, divide_by_zero, zero fill
   output logic [fwalu_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata
);

   fwalu_pkg::ctrl_cmd_type  cmd;
   fwalu_pkg::dp_status_type status;

   fwalu_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   fwalu_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_tdata (req_tdata),
      .status    (status),
      .rsp_tdata (rsp_tdata)
   );

endmodule

### sv/fwalu_ctrl.sv
// Sequencing state machine and response valid flag for the ALU.
module fwalu_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  fwalu_pkg::dp_status_type status,
   output fwalu_pkg::ctrl_cmd_type  cmd
);

   fwalu_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fwalu_pkg::S_IDLE: begin
            if (req_tvalid) state_in = fwalu_pkg::S_DECIDE;
         end
         fwalu_pkg::S_DECIDE: begin
            state_in = status.iterative ? fwalu_pkg::S_RUN : fwalu_pkg::S_FINISH;
         end
         fwalu_pkg::S_RUN: begin
            if (status.last) state_in = fwalu_pkg::S_FINISH;
         end
         fwalu_pkg::S_FINISH: begin
            if (out_free) state_in = fwalu_pkg::S_IDLE;
         end
         default: state_in = fwalu_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      req_tready    = 1'b0;
      cmd.load      = 1'b0;
      cmd.step      = 1'b0;
      cmd.write_out = 1'b0;
      unique case (state_ff)
         fwalu_pkg::S_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         fwalu_pkg::S_DECIDE: begin
         end
         fwalu_pkg::S_RUN: begin
            cmd.step = 1'b1;
         end
         fwalu_pkg::S_FINISH: begin
            cmd.write_out = out_free;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.write_out) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fwalu_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   a_accept_decides: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> state_ff == fwalu_pkg::S_DECIDE)
      else $error("accepted request did not move to decide");

   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fwalu_pkg::S_RUN && status.last) |=> state_ff == fwalu_pkg::S_FINISH)
      else $error("iteration ran past its last step");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.write_out |-> (!rsp_valid_ff || rsp_tready))
      else $error("pending response overwritten");

endmodule

### sv/fwalu_datapath.sv
// Operand registers, shift-add multiplier, restoring divider and result register.
module fwalu_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  fwalu_pkg::ctrl_cmd_type             cmd,
   input  logic [fwalu_pkg::REQ_TDATA_WIDTH-1:0] req_tdata,
   output fwalu_pkg::dp_status_type            status,
   output logic [fwalu_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata
);

   localparam int W = fwalu_pkg::WIDTH;
   localparam int CW = fwalu_pkg::COUNT_WIDTH;
   localparam int FW = fwalu_pkg::FIELD_WIDTH;
   localparam int RTW = fwalu_pkg::RSP_TDATA_WIDTH;

   fwalu_pkg::op_type op_ff;
   logic [W-1:0] a_ff, a_in;
   logic [W-1:0] b_ff, b_in;
   logic [W-1:0] acc_ff, acc_in;
   logic [fwalu_pkg::SHIFT_WIDTH-1:0] sh_ff;
   logic [CW-1:0] count_ff;

   logic [W-1:0] value_ff, value_in;
   logic cmp_ff, cmp_in;
   logic dz_ff, dz_in;

   logic is_divmod;
   logic b_zero;
   logic big_shift;
   logic [W:0] rem_shift;
   logic [W:0] rem_diff;
   logic rem_fits;

   assign is_divmod = (op_ff == fwalu_pkg::OP_DIV) || (op_ff == fwalu_pkg::OP_MOD);
   assign b_zero = (b_ff == '0);
   assign big_shift = ({{(32 - fwalu_pkg::SHIFT_WIDTH){1'b0}}, sh_ff} >= 32'(W));

   assign status.iterative = (op_ff == fwalu_pkg::OP_MUL) || (is_divmod && !b_zero);
   assign status.last = (count_ff == '0);

   // restoring divide: bring in the next dividend bit and try the subtract
   assign rem_shift = {acc_ff, a_ff[W-1]};
   assign rem_diff = rem_shift - {1'b0, b_ff};
   assign rem_fits = (rem_shift >= {1'b0, b_ff});

   always_comb begin
      a_in   = a_ff;
      b_in   = b_ff;
      acc_in = acc_ff;
      if (cmd.load) begin
         a_in   = req_tdata[fwalu_pkg::REQ_A_LSB +: W];
         b_in   = req_tdata[fwalu_pkg::REQ_B_LSB +: W];
         acc_in = '0;
      end else if (cmd.step) begin
         if (op_ff == fwalu_pkg::OP_MUL) begin
            if (b_ff[0]) acc_in = acc_ff + a_ff;
            a_in = {a_ff[W-2:0], 1'b0};
            b_in = {1'b0, b_ff[W-1:1]};
         end else begin
            acc_in = rem_fits ? rem_diff[W-1:0] : rem_shift[W-1:0];
            a_in   = {a_ff[W-2:0], rem_fits};
         end
      end
   end

   always_comb begin
      value_in = '0;
      cmp_in   = 1'b0;
      dz_in    = 1'b0;
      case (op_ff)
         fwalu_pkg::OP_ADD: value_in = a_ff + b_ff;
         fwalu_pkg::OP_SUB: value_in = a_ff - b_ff;
         fwalu_pkg::OP_MUL: value_in = acc_ff;
         fwalu_pkg::OP_DIV: begin
            dz_in = b_zero;
            if (!b_zero) value_in = a_ff;
         end
         fwalu_pkg::OP_MOD: begin
            dz_in = b_zero;
            if (!b_zero) value_in = acc_ff;
         end
         fwalu_pkg::OP_SHL: value_in = big_shift ? '0 : (a_ff << sh_ff);
         fwalu_pkg::OP_SHR: value_in = big_shift ? '0 : (a_ff >> sh_ff);
         fwalu_pkg::OP_GT:  cmp_in = (a_ff > b_ff);
         fwalu_pkg::OP_LT:  cmp_in = (a_ff < b_ff);
         fwalu_pkg::OP_EQ:  cmp_in = (a_ff == b_ff);
         fwalu_pkg::OP_LE:  cmp_in = (a_ff <= b_ff);
         fwalu_pkg::OP_GE:  cmp_in = (a_ff >= b_ff);
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
      if (cmd.load) begin
         op_ff    <= fwalu_pkg::op_type'(req_tdata[fwalu_pkg::REQ_OP_LSB +: fwalu_pkg::OP_WIDTH]);
         sh_ff    <= req_tdata[fwalu_pkg::REQ_SH_LSB +: fwalu_pkg::SHIFT_WIDTH];
         count_ff <= CW'(W - 1);
      end else if (cmd.step) begin
         count_ff <= count_ff - CW'(1);
      end
      if (cmd.write_out) begin
         value_ff <= value_in;
         cmp_ff   <= cmp_in;
         dz_ff    <= dz_in;
      end
   end

   assign rsp_tdata = RTW'({dz_ff, cmp_ff, FW'(value_ff)});

   a_step_iterative: assert property (@(posedge clock) disable iff (reset)
      (cmd.step && op_ff != fwalu_pkg::OP_MUL) |-> is_divmod && !b_zero)
      else $error("divide step on a non-divide or zero divisor");

   a_dz_only_divmod: assert property (@(posedge clock) disable iff (reset)
      (cmd.write_out && !is_divmod) |=> !dz_ff)
      else $error("divide-by-zero flag raised on another operation");

   a_count_loaded: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> !status.last)
      else $error("step counter not loaded with a full run");

endmodule

### bench/fixed_width_unsigned_alu_tb.sv
// Self-checking testbench for the fixed-width unsigned ALU over its request and response streams.
module fixed_width_unsigned_alu_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 80;
   localparam int RANDOM_REQUESTS = 830;
   localparam int REPORT_LIMIT = 10;
   localparam int OP_BITS = fwalu_pkg::OP_WIDTH;
   localparam int SH_BITS = fwalu_pkg::SHIFT_WIDTH;
   localparam int FW = fwalu_pkg::FIELD_WIDTH;
   localparam logic [OP_BITS-1:0] OP_UNDEF_FIRST = 4'd12;
   localparam logic [OP_BITS-1:0] OP_UNDEF_LAST = 4'd15;
   localparam logic [FW-1:0] ALL_ONES = {FW{1'b1}};

   typedef struct packed {
      logic [FW-1:0] value;
      logic          compare_true;
      logic          divide_by_zero;
   } alu_outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [fwalu_pkg::REQ_TDATA_WIDTH-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [fwalu_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata;

   alu_outcome_type pending_outcomes[$];
   int mismatch_count = 0;
   int burst_left = 0;
   int stall_left = 0;
   int tick = 0;

   fixed_width_unsigned_alu uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #6 clock = ~clock;

   function automatic logic [fwalu_pkg::REQ_TDATA_WIDTH-1:0] pack_request(
         input logic [OP_BITS-1:0] op,
         input logic [FW-1:0] a, input logic [FW-1:0] b,
         input logic [SH_BITS-1:0] sh);
      logic [fwalu_pkg::REQ_TDATA_WIDTH-1:0] word;
      word = '0;
      word[fwalu_pkg::REQ_OP_LSB +: OP_BITS] = op;
      word[fwalu_pkg::REQ_A_LSB +: FW] = a;
      word[fwalu_pkg::REQ_B_LSB +: FW] = b;
      word[fwalu_pkg::REQ_SH_LSB +: SH_BITS] = sh;
      return word;
   endfunction

   // Expected response for one request word
   function automatic alu_outcome_type alu_outcome(
         input logic [fwalu_pkg::REQ_TDATA_WIDTH-1:0] word);
      logic [FW-1:0] mask;
      logic [FW-1:0] a;
      logic [FW-1:0] b;
      logic [OP_BITS-1:0] op;
      logic [SH_BITS-1:0] sh;
      alu_outcome_type r;
      mask = ALL_ONES >> (FW - fwalu_pkg::WIDTH);
      op = word[fwalu_pkg::REQ_OP_LSB +: OP_BITS];
      a = word[fwalu_pkg::REQ_A_LSB +: FW] & mask;
      b = word[fwalu_pkg::REQ_B_LSB +: FW] & mask;
      sh = word[fwalu_pkg::REQ_SH_LSB +: SH_BITS];
      r = '0;
      case (op)
         fwalu_pkg::OP_ADD: r.value = a + b;
         fwalu_pkg::OP_SUB: r.value = a - b;
         fwalu_pkg::OP_MUL: r.value = a * b;
         fwalu_pkg::OP_DIV: begin
            if (b == '0) r.divide_by_zero = 1'b1;
            else r.value = a / b;
         end
         fwalu_pkg::OP_MOD: begin
            if (b == '0) r.divide_by_zero = 1'b1;
            else r.value = a % b;
         end
         fwalu_pkg::OP_SHL: r.value = (sh >= fwalu_pkg::WIDTH) ? '0 : (a << sh);
         fwalu_pkg::OP_SHR: r.value = (sh >= fwalu_pkg::WIDTH) ? '0 : (a >> sh);
         fwalu_pkg::OP_GT: r.compare_true = (a > b);
         fwalu_pkg::OP_LT: r.compare_true = (a < b);
         fwalu_pkg::OP_EQ: r.compare_true = (a == b);
         fwalu_pkg::OP_LE: r.compare_true = (a <= b);
         fwalu_pkg::OP_GE: r.compare_true = (a >= b);
         default: ;
      endcase
      r.value = r.value & mask;
      return r;
   endfunction

   // Hand one request over, sometimes idling between bursts of random length
   task automatic send_request(input logic [OP_BITS-1:0] op, input logic [FW-1:0] a,
         input logic [FW-1:0] b, input logic [SH_BITS-1:0] sh);
      int idle;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
         if (idle > 0) begin
            req_tvalid <= 1'b0;
            repeat (idle) @(posedge clock);
         end
      end
      burst_left--;
      req_tdata <= pack_request(op, a, b, sh);
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   function automatic logic [FW-1:0] pick_operand();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return ALL_ONES;
         2: return 64'd1 << $urandom_range(0, FW - 1);
         3: return 64'($urandom_range(0, 255));
         4: return ALL_ONES - 64'($urandom_range(0, 255));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic test_arith_extremes();
      send_request(fwalu_pkg::OP_ADD, ALL_ONES, 64'd1, 7'd0);
      send_request(fwalu_pkg::OP_ADD, '0, '0, 7'd0);
      send_request(fwalu_pkg::OP_SUB, '0, 64'd1, 7'd0);
      send_request(fwalu_pkg::OP_MUL, ALL_ONES, ALL_ONES, 7'd0);
   endtask

   task automatic test_divide();
      send_request(fwalu_pkg::OP_DIV, ALL_ONES, '0, 7'd0);
      send_request(fwalu_pkg::OP_MOD, 64'd5, '0, 7'd0);
      send_request(fwalu_pkg::OP_DIV, ALL_ONES, 64'd1, 7'd0);
      send_request(fwalu_pkg::OP_MOD, ALL_ONES, ALL_ONES - 64'd1, 7'd0);
      send_request(fwalu_pkg::OP_DIV, 64'd3, 64'd7, 7'd0);
   endtask

   task automatic test_shifts();
      send_request(fwalu_pkg::OP_SHL, ALL_ONES, '0, 7'd0);
      send_request(fwalu_pkg::OP_SHL, ALL_ONES, '0, 7'd63);
      send_request(fwalu_pkg::OP_SHL, ALL_ONES, '0, 7'd64);
      send_request(fwalu_pkg::OP_SHR, ALL_ONES, '0, 7'd127);
      send_request(fwalu_pkg::OP_SHR, ALL_ONES, ALL_ONES, 7'd63);
   endtask

   task automatic test_compares();
      send_request(fwalu_pkg::OP_GT, ALL_ONES, '0, 7'd0);
      send_request(fwalu_pkg::OP_LT, '0, ALL_ONES, 7'd0);
      send_request(fwalu_pkg::OP_EQ, ALL_ONES, ALL_ONES, 7'd0);
      send_request(fwalu_pkg::OP_LE, 64'd42, 64'd42, 7'd0);
      send_request(fwalu_pkg::OP_GE, '0, 64'd1, 7'd0);
      send_request(fwalu_pkg::OP_GT, 64'd42, 64'd42, 7'd0);
   endtask

   task automatic test_undefined_ops();
      send_request(OP_UNDEF_FIRST, ALL_ONES, ALL_ONES, 7'd127);
      send_request(OP_UNDEF_LAST, ALL_ONES, '0, 7'd1);
   endtask

   task automatic test_random_mix();
      logic [OP_BITS-1:0] op;
      logic [FW-1:0] a;
      logic [FW-1:0] b;
      logic [SH_BITS-1:0] sh;
      repeat (RANDOM_REQUESTS) begin
         op = ($urandom_range(0, 15) == 0) ? OP_BITS'($urandom_range(12, 15))
                                           : OP_BITS'($urandom_range(0, 11));
         a = pick_operand();
         b = ($urandom_range(0, 4) == 0) ? a : pick_operand();
         sh = ($urandom_range(0, 3) == 0) ? SH_BITS'($urandom_range(0, 127))
                                          : SH_BITS'($urandom_range(0, 64));
         send_request(op, a, b, sh);
      end
   endtask

   // Receiver: alternate free-running, random, fixed-pattern and long-stall stretches
   always @(posedge clock) begin
      tick <= tick + 1;
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         case ((tick / 256) % 4)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 2) != 0);
            2: rsp_tready <= (tick % 5) != 1 && (tick % 7) != 3;
            default: begin
               if ($urandom_range(0, 15) == 0) begin
                  stall_left <= $urandom_range(1, 40);
                  rsp_tready <= 1'b0;
               end else begin
                  rsp_tready <= 1'b1;
               end
            end
         endcase
      end
   end

   // Record each accepted request and check each accepted response
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_outcomes.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("unexpected response: value=%h cmp=%b dz=%b",
                        rsp_tdata[FW-1:0], rsp_tdata[FW], rsp_tdata[FW+1]);
         end else begin
            alu_outcome_type want;
            want = pending_outcomes.pop_front();
            if (rsp_tdata[FW-1:0] !== want.value
                  || rsp_tdata[FW] !== want.compare_true
                  || rsp_tdata[FW+1] !== want.divide_by_zero) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("mismatch: expected value=%h cmp=%b dz=%b, got value=%h cmp=%b dz=%b",
                           want.value, want.compare_true, want.divide_by_zero,
                           rsp_tdata[FW-1:0], rsp_tdata[FW], rsp_tdata[FW+1]);
            end
         end
      end
      if (!reset && req_tvalid && req_tready)
         pending_outcomes.insert(pending_outcomes.size(), alu_outcome(req_tdata));
   end

   // Watchdog: end the run when nothing moves for too long
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (reset) @(posedge clock);
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("FAIL");
      $finish;
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_arith_extremes();
      test_divide();
      test_shifts();
      test_compares();
      test_undefined_ops();
      test_random_mix();
      req_tvalid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

### sim.f
sv/fwalu_pkg.sv
sv/fwalu_ctrl.sv
sv/fwalu_datapath.sv
sv/fixed_width_unsigned_alu.sv
bench/fixed_width_unsigned_alu_tb.sv
